// ===== sv/hll_pkg.sv =====
// Shared constants for the HyperLogLog sketch engine.
// Used by hll_rank and hyperloglog_sketch_engine; no dependencies.
package hll_pkg;

    localparam int MAX_PRECISION_DEF = 14;
    localparam int PREC_MIN          = 4;
    localparam int PREC_W            = 4;
    localparam int EPREC_W           = 5;
    localparam int HASH_W            = 64;
    localparam int RANK_W            = 6;
    localparam int FRAC_BITS         = 40;

    localparam logic [HASH_W-1:0] HASH_SEED = 64'h0000_0000_DEAD_BEEF;
    // The 64-bit prime is 2^40 + 0x1B3.
    localparam int                PRIME_HI_SHIFT = 40;
    localparam logic [8:0]        PRIME_LO       = 9'h1B3;

    localparam logic [1:0] REQ_DATA  = 2'd0;
    localparam logic [1:0] REQ_MERGE = 2'd1;
    localparam logic [1:0] REQ_EST   = 2'd2;
    localparam logic [1:0] REQ_CLEAR = 2'd3;

endpackage

// ===== sv/hll_rank.sv =====
// Entry index and rank from a finished item hash.
// Uses hll_pkg for widths.
module hll_rank #(
    parameter int MAX_PRECISION = hll_pkg::MAX_PRECISION_DEF
) (
    input  logic [hll_pkg::HASH_W-1:0]  hash,
    input  logic [hll_pkg::EPREC_W-1:0] prec,
    output logic [MAX_PRECISION-1:0]    index,
    output logic [hll_pkg::RANK_W-1:0]  rank
);

    logic [hll_pkg::HASH_W-1:0] top;
    logic [hll_pkg::HASH_W-1:0] w;
    logic [7:0]                 nz;
    logic [2:0]                 lzb [8];
    logic [6:0]                 lz;

    assign top   = hash >> (7'd64 - 7'(prec));
    assign index = top[MAX_PRECISION-1:0];
    assign w     = hash << prec;

    always_comb
    begin
        logic fb;
        for (int k = 0; k < 8; k++)
        begin
            nz[k]  = |w[8*k +: 8];
            lzb[k] = 3'd0;
            fb     = 1'b0;
            for (int i = 7; i >= 0; i--)
            begin
                if (!fb && w[8*k + i])
                begin
                    lzb[k] = 3'(7 - i);
                    fb     = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        logic found;
        found = 1'b0;
        lz    = 7'd0;
        for (int k = 7; k >= 0; k--)
        begin
            if (!found && nz[k])
            begin
                lz    = 7'((7 - k) * 8) + {4'd0, lzb[k]};
                found = 1'b1;
            end
        end
    end

    always_comb
    begin
        if (nz == 8'd0)
            rank = hll_pkg::RANK_W'(7'd65 - 7'(prec));
        else
            rank = hll_pkg::RANK_W'(lz + 7'd1);
    end

endmodule

// ===== sv/hyperloglog_sketch_engine.sv =====
// HyperLogLog rank store with FNV-1a-style byte hashing (non-standard seed); top level.
// Last byte: ST_RANK, ST_UPD; merge: ST_UPD, or dropped if out of range; clear: every entry.
// Estimate: walk of active entries, ST_ESTF, one result_valid strobe; the receiver cannot stall.
// Each item is limited by the rank memory (one read, one write port) for read-modify-write or a walk.
// Reset: asynchronous; a clearing pass over all 2^MAX_PRECISION entries holds busy high.
// Uses hll_pkg and hll_rank.
module hyperloglog_sketch_engine #(
    parameter int MAX_PRECISION = hll_pkg::MAX_PRECISION_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       req_type,
    input  logic [7:0]                       data_byte,
    input  logic                             last_byte,
    input  logic [MAX_PRECISION-1:0]         entry_index,
    input  logic [hll_pkg::RANK_W-1:0]       entry_value,
    input  logic                             precision_we,
    input  logic [hll_pkg::PREC_W-1:0]       precision_wdata,
    output logic                             result_valid,
    output logic [MAX_PRECISION+40:0]        harmonic_sum,
    output logic [MAX_PRECISION:0]           zero_count
);

    localparam int DEPTH = 1 << MAX_PRECISION;
    localparam int SUM_W = MAX_PRECISION + hll_pkg::FRAC_BITS + 1;
    localparam int CNT_W = MAX_PRECISION + 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CLR  = 3'd1;
    localparam logic [2:0] ST_RANK = 3'd2;
    localparam logic [2:0] ST_UPD  = 3'd3;
    localparam logic [2:0] ST_EST  = 3'd4;
    localparam logic [2:0] ST_ESTF = 3'd5;

    logic [2:0]                    state_reg, state_next;
    logic [MAX_PRECISION-1:0]      addr_reg, addr_next;
    logic [hll_pkg::HASH_W-1:0]    hash_reg, hash_next;
    logic [hll_pkg::PREC_W-1:0]    precision_reg;
    logic                          result_valid_reg;
    logic                          acc_vld_reg;

    logic [hll_pkg::HASH_W-1:0]    hfin_reg;
    logic [MAX_PRECISION-1:0]      upd_idx_reg;
    logic [hll_pkg::RANK_W-1:0]    upd_val_reg;
    logic [SUM_W-1:0]              sum_reg;
    logic [CNT_W-1:0]              zero_reg;
    logic [SUM_W-1:0]              harmonic_sum_reg;
    logic [CNT_W-1:0]              zero_count_reg;

    logic [hll_pkg::RANK_W-1:0]    rank_mem [DEPTH];
    logic [hll_pkg::RANK_W-1:0]    mem_rdata_reg;
    logic                          mem_we, mem_re;
    logic [MAX_PRECISION-1:0]      mem_waddr, mem_raddr;
    logic [hll_pkg::RANK_W-1:0]    mem_wdata;

    logic [hll_pkg::EPREC_W-1:0]   prec_eff;
    logic [CNT_W-1:0]              count;
    logic [MAX_PRECISION-1:0]      last_idx;
    logic                          accept;
    logic                          merge_ok;
    logic [hll_pkg::HASH_W-1:0]    h_x, h_mul;
    logic [MAX_PRECISION-1:0]      rk_index;
    logic [hll_pkg::RANK_W-1:0]    rk_rank;
    logic [SUM_W-1:0]              term;
    logic [SUM_W-1:0]              sum_add;
    logic [CNT_W-1:0]              zero_add;

    always_comb
    begin
        if (int'(precision_reg) < hll_pkg::PREC_MIN)
            prec_eff = hll_pkg::EPREC_W'(hll_pkg::PREC_MIN);
        else if (int'(precision_reg) > MAX_PRECISION)
            prec_eff = hll_pkg::EPREC_W'(MAX_PRECISION);
        else
            prec_eff = hll_pkg::EPREC_W'(precision_reg);
    end

    assign count    = CNT_W'(1) << prec_eff;
    assign last_idx = MAX_PRECISION'(count - CNT_W'(1));
    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign merge_ok = ({1'b0, entry_index} < count);

    assign h_x   = hash_reg ^ {56'd0, data_byte};
    assign h_mul = (h_x << hll_pkg::PRIME_HI_SHIFT) + (h_x * 64'(hll_pkg::PRIME_LO));

    hll_rank #(
        .MAX_PRECISION(MAX_PRECISION)
    ) u_rank (
        .hash  (hfin_reg),
        .prec  (prec_eff),
        .index (rk_index),
        .rank  (rk_rank)
    );

    always_comb
    begin
        if (mem_rdata_reg <= hll_pkg::RANK_W'(hll_pkg::FRAC_BITS))
            term = SUM_W'(1) << (6'(hll_pkg::FRAC_BITS) - mem_rdata_reg);
        else
            term = '0;
    end

    assign sum_add  = sum_reg + term;
    assign zero_add = zero_reg + CNT_W'(mem_rdata_reg == '0);

    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        hash_next  = hash_reg;
        mem_re     = 1'b0;
        mem_raddr  = addr_reg;
        mem_we     = 1'b0;
        mem_waddr  = addr_reg;
        mem_wdata  = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req_type)
                        hll_pkg::REQ_DATA:
                        begin
                            if (last_byte)
                            begin
                                hash_next  = hll_pkg::HASH_SEED;
                                state_next = ST_RANK;
                            end
                            else
                                hash_next = h_mul;
                        end
                        hll_pkg::REQ_MERGE:
                        begin
                            if (merge_ok)
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = entry_index;
                                state_next = ST_UPD;
                            end
                        end
                        hll_pkg::REQ_EST:
                        begin
                            addr_next  = '0;
                            state_next = ST_EST;
                        end
                        hll_pkg::REQ_CLEAR:
                        begin
                            addr_next  = '0;
                            state_next = ST_CLR;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CLR:
            begin
                mem_we    = 1'b1;
                mem_waddr = addr_reg;
                addr_next = addr_reg + MAX_PRECISION'(1);
                if (addr_reg == '1)
                    state_next = ST_IDLE;
            end
            ST_RANK:
            begin
                mem_re     = 1'b1;
                mem_raddr  = rk_index;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                mem_waddr = upd_idx_reg;
                mem_wdata = upd_val_reg;
                mem_we    = (upd_val_reg > mem_rdata_reg);
                state_next = ST_IDLE;
            end
            ST_EST:
            begin
                mem_re    = 1'b1;
                mem_raddr = addr_reg;
                addr_next = addr_reg + MAX_PRECISION'(1);
                if (addr_reg == last_idx)
                    state_next = ST_ESTF;
            end
            ST_ESTF:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLR;
            addr_reg         <= '0;
            hash_reg         <= hll_pkg::HASH_SEED;
            precision_reg    <= hll_pkg::PREC_W'(hll_pkg::MAX_PRECISION_DEF);
            result_valid_reg <= 1'b0;
            acc_vld_reg      <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            addr_reg         <= addr_next;
            hash_reg         <= hash_next;
            result_valid_reg <= (state_reg == ST_ESTF);
            acc_vld_reg      <= (state_reg == ST_EST);
            if (precision_we)
                precision_reg <= precision_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && req_type == hll_pkg::REQ_DATA && last_byte)
            hfin_reg <= h_mul;
        if (accept && req_type == hll_pkg::REQ_MERGE)
        begin
            upd_idx_reg <= entry_index;
            upd_val_reg <= entry_value;
        end
        else if (state_reg == ST_RANK)
        begin
            upd_idx_reg <= rk_index;
            upd_val_reg <= rk_rank;
        end
        if (accept && req_type == hll_pkg::REQ_EST)
        begin
            sum_reg  <= '0;
            zero_reg <= '0;
        end
        else if (acc_vld_reg)
        begin
            sum_reg  <= sum_add;
            zero_reg <= zero_add;
        end
        if (state_reg == ST_ESTF)
        begin
            harmonic_sum_reg <= sum_add;
            zero_count_reg   <= zero_add;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            rank_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            mem_rdata_reg <= rank_mem[mem_raddr];
    end

    assign result_valid = result_valid_reg;
    assign harmonic_sum = harmonic_sum_reg;
    assign zero_count   = zero_count_reg;

    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe longer than one cycle");

    a_est_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req_type == hll_pkg::REQ_EST) |=> busy)
        else $error("estimate accepted without going busy");

    a_zero_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (zero_count <= count))
        else $error("zero count exceeds active entry count");

    a_hash_reseed: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req_type == hll_pkg::REQ_DATA && last_byte)
        |=> (hash_reg == hll_pkg::HASH_SEED))
        else $error("hash not reseeded after last byte");

    a_upd_after_rank: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RANK) |=> (state_reg == ST_UPD))
        else $error("rank lookup not followed by update");

endmodule
